// ----- hdl/ile_pkg.sv -----
// Package for the interface length estimator: register codes, reset values,
// fixed-point constants, sequencer states and the shared multiply unit types.
// No dependencies.
package ile_pkg;

    localparam int ILE_MAX_GRID_DEF = 256;

    localparam int ILE_DATA_W = 64;
    localparam int ILE_MULT_W = 32;
    localparam int ILE_MAC_STEPS = 32;

    localparam logic ILE_REG_GRID_SIZE    = 1'b0;
    localparam logic ILE_REG_CELL_SPACING = 1'b1;

    localparam logic [8:0]  ILE_GRID_RESET    = 9'd256;
    localparam logic [23:0] ILE_SPACING_RESET = 24'd65536;

    localparam logic [31:0] ILE_SQRT2_Q20 = 32'd1482910;
    localparam logic [31:0] ILE_PI32_Q32  = 32'd421657428;
    localparam logic [63:0] ILE_LO_ROUND  = 64'd1 << 51;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_sign;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_NEXT,
        S_UPDATE,
        S_MUL_S,
        S_MUL_T,
        S_MUL_LO,
        S_MUL_HI,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [ILE_DATA_W-1:0] init;
        logic [ILE_DATA_W-1:0] a;
        logic [ILE_MULT_W-1:0] b;
    } t_mac_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [ILE_DATA_W-1:0] product;
    } t_mac_rsp;

    function automatic t_sign ile_sign(input logic [15:0] s);
        t_sign res;
        if (s == 16'd0) begin
            res = SIGN_ZERO;
        end else if (s[15]) begin
            res = SIGN_NEG;
        end else begin
            res = SIGN_POS;
        end
        return res;
    endfunction

    function automatic logic ile_crosses(input t_sign x, input t_sign y);
        return (x != SIGN_ZERO) && (y != SIGN_ZERO) && (x != y);
    endfunction

endpackage

// ----- hdl/interface_length_estimator.sv -----
// Each sample passes through accept, a second line-buffer read and update, and no new
// sample is taken until the update is done. The last sample of a frame then adds four
// passes of the shared shift-add unit (start, a step per multiplier bit, done) and a load
// step, which also waits for the output register. Frame position is kept across
// register writes.
// Top level of the interface length estimator. Depends on ile_pkg and ile_mac.
module interface_length_estimator
    import ile_pkg::*;
#(
    parameter int MAX_GRID = ILE_MAX_GRID_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [39:0] o_length_estimate,
    output logic [15:0] o_horizontal_crossings,
    output logic [15:0] o_vertical_crossings,
    output logic [14:0] o_diagonal_crossings,
    output logic [14:0] o_antidiagonal_crossings
);

    localparam int AW = $clog2(MAX_GRID);
    localparam int NW = $clog2(MAX_GRID + 1);
    localparam int XW = ((NW > 9) ? NW : 9) + 1;
    localparam int HW = 2 * AW;
    localparam int DW = HW - 1;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_row, n_row;
    t_sign           r_left, n_left;
    t_sign           r_upleft, n_upleft;
    t_sign           r_cur, n_cur;
    t_sign           r_above, n_above;
    logic [HW-1:0]   r_cnt_h, n_cnt_h;
    logic [HW-1:0]   r_cnt_v, n_cnt_v;
    logic [DW-1:0]   r_cnt_d, n_cnt_d;
    logic [DW-1:0]   r_cnt_a, n_cnt_a;
    logic            r_mac_go, n_mac_go;
    logic [63:0]     r_t, n_t;
    logic            r_out_valid, n_out_valid;
    logic [39:0]     r_out_len, n_out_len;
    logic [15:0]     r_out_h, n_out_h;
    logic [15:0]     r_out_v, n_out_v;
    logic [14:0]     r_out_d, n_out_d;
    logic [14:0]     r_out_a, n_out_a;
    logic [8:0]      r_grid_size;
    logic [23:0]     r_spacing;

    t_sign           r_mem [MAX_GRID];
    t_sign           r_rd_data;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;

    t_mac_req        mac_req;
    t_mac_rsp        mac_rsp;

    logic [XW-1:0]   gs_x;
    logic [XW-1:0]   n_eff;
    logic [XW-1:0]   col_x;
    logic [XW-1:0]   row_x;
    logic            col_last;
    logic            row_last;
    logic            cross_h;
    logic            cross_v;
    logic            cross_d;
    logic            cross_a;
    logic [HW:0]     sum_hv;
    logic [DW:0]     sum_da;
    logic            cfg_wr;

    ile_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_rsp   (mac_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= ILE_GRID_RESET;
            r_spacing   <= ILE_SPACING_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                ILE_REG_GRID_SIZE:    r_grid_size <= pwdata[8:0];
                ILE_REG_CELL_SPACING: r_spacing   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ILE_REG_GRID_SIZE:    prdata = 32'(r_grid_size);
            ILE_REG_CELL_SPACING: prdata = 32'(r_spacing);
            default:              prdata = '0;
        endcase
    end

    // effective grid size and position tests
    always_comb begin
        gs_x = XW'(r_grid_size);
        if (gs_x < XW'(2)) begin
            n_eff = XW'(2);
        end else if (gs_x > XW'(MAX_GRID)) begin
            n_eff = XW'(MAX_GRID);
        end else begin
            n_eff = gs_x;
        end
    end

    assign col_x    = XW'(r_col);
    assign row_x    = XW'(r_row);
    assign col_last = (col_x + XW'(1)) >= n_eff;
    assign row_last = (row_x + XW'(1)) >= n_eff;

    assign cross_h = (r_col != '0) && ile_crosses(r_cur, r_left);
    assign cross_v = (r_row != '0) && ile_crosses(r_cur, r_above);
    assign cross_d = (r_row != '0) && ((row_x + col_x) <= (n_eff - XW'(1)))
                     && ((col_x + XW'(1)) < XW'(MAX_GRID))
                     && ile_crosses(r_cur, r_rd_data);
    assign cross_a = (r_row != '0) && (r_col != '0) && (r_col <= r_row)
                     && ile_crosses(r_cur, r_upleft);

    assign sum_hv = (HW + 1)'(r_cnt_h) + (HW + 1)'(r_cnt_v);
    assign sum_da = (DW + 1)'(r_cnt_d) + (DW + 1)'(r_cnt_a);

    // row sign store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_col] <= r_cur;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= SIGN_ZERO;
            r_upleft    <= SIGN_ZERO;
            r_cnt_h     <= '0;
            r_cnt_v     <= '0;
            r_cnt_d     <= '0;
            r_cnt_a     <= '0;
            r_mac_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_left      <= n_left;
            r_upleft    <= n_upleft;
            r_cnt_h     <= n_cnt_h;
            r_cnt_v     <= n_cnt_v;
            r_cnt_d     <= n_cnt_d;
            r_cnt_a     <= n_cnt_a;
            r_mac_go    <= n_mac_go;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_above   <= n_above;
        r_t       <= n_t;
        r_out_len <= n_out_len;
        r_out_h   <= n_out_h;
        r_out_v   <= n_out_v;
        r_out_d   <= n_out_d;
        r_out_a   <= n_out_a;
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_left      = r_left;
        n_upleft    = r_upleft;
        n_cur       = r_cur;
        n_above     = r_above;
        n_cnt_h     = r_cnt_h;
        n_cnt_v     = r_cnt_v;
        n_cnt_d     = r_cnt_d;
        n_cnt_a     = r_cnt_a;
        n_mac_go    = 1'b0;
        n_t         = r_t;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_len   = r_out_len;
        n_out_h     = r_out_h;
        n_out_v     = r_out_v;
        n_out_d     = r_out_d;
        n_out_a     = r_out_a;
        mem_we      = 1'b0;
        rd_addr     = r_col;
        mac_req     = '{start: r_mac_go, init: '0, a: '0, b: '0};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur   = ile_sign(i_sample);
                    n_state = S_RD_NEXT;
                end
            end
            S_RD_NEXT: begin
                rd_addr = r_col + AW'(1);
                n_above = r_rd_data;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                mem_we   = 1'b1;
                n_cnt_h  = r_cnt_h + HW'(cross_h);
                n_cnt_v  = r_cnt_v + HW'(cross_v);
                n_cnt_d  = r_cnt_d + DW'(cross_d);
                n_cnt_a  = r_cnt_a + DW'(cross_a);
                n_upleft = r_above;
                n_left   = r_cur;
                n_state  = S_IDLE;
                if (col_last) begin
                    n_col = '0;
                    if (row_last) begin
                        n_row    = '0;
                        n_left   = SIGN_ZERO;
                        n_upleft = SIGN_ZERO;
                        n_mac_go = 1'b1;
                        n_state  = S_MUL_S;
                    end else begin
                        n_row = r_row + AW'(1);
                    end
                end else begin
                    n_col = r_col + AW'(1);
                end
            end
            S_MUL_S: begin
                mac_req.init = 64'(sum_hv) << 20;
                mac_req.a    = 64'(sum_da);
                mac_req.b    = ILE_SQRT2_Q20;
                if (mac_rsp.done) begin
                    n_mac_go = 1'b1;
                    n_state  = S_MUL_T;
                end
            end
            S_MUL_T: begin
                mac_req.a = mac_rsp.product;
                mac_req.b = 32'(r_spacing);
                if (mac_rsp.done) begin
                    n_t      = mac_rsp.product;
                    n_mac_go = 1'b1;
                    n_state  = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                mac_req.init = ILE_LO_ROUND;
                mac_req.a    = 64'(r_t[31:0]);
                mac_req.b    = ILE_PI32_Q32;
                if (mac_rsp.done) begin
                    n_mac_go = 1'b1;
                    n_state  = S_MUL_HI;
                end
            end
            S_MUL_HI: begin
                mac_req.init = mac_rsp.product >> 32;
                mac_req.a    = 64'(r_t[63:32]);
                mac_req.b    = ILE_PI32_Q32;
                if (mac_rsp.done) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_len   = mac_rsp.product[59:20];
                    n_out_h     = 16'(r_cnt_h);
                    n_out_v     = 16'(r_cnt_v);
                    n_out_d     = 15'(r_cnt_d);
                    n_out_a     = 15'(r_cnt_a);
                    n_cnt_h     = '0;
                    n_cnt_v     = '0;
                    n_cnt_d     = '0;
                    n_cnt_a     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready               = (r_state == S_IDLE);
    assign o_out_valid              = r_out_valid;
    assign o_length_estimate        = r_out_len;
    assign o_horizontal_crossings   = r_out_h;
    assign o_vertical_crossings     = r_out_v;
    assign o_diagonal_crossings     = r_out_d;
    assign o_antidiagonal_crossings = r_out_a;

    a_new_frame_counts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_row == '0 && r_col == '0)
        |-> (r_cnt_h == '0 && r_cnt_v == '0 && r_cnt_d == '0 && r_cnt_a == '0))
        else $error("counts not cleared at frame start");

    a_no_accept_while_mac_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !mac_rsp.busy)
        else $error("item accepted while length unit busy");

    a_mac_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_rsp.done |-> (r_state == S_MUL_S || r_state == S_MUL_T
                          || r_state == S_MUL_LO || r_state == S_MUL_HI))
        else $error("length unit finished outside a multiply step");

endmodule

// ----- hdl/ile_mac.sv -----
// Shared shift-add multiply-accumulate unit: product = init + a * b, mod 2^64,
// one multiplier bit per cycle. Depends on ile_pkg.
module ile_mac
    import ile_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_req i_req,
    output t_mac_rsp o_rsp
);

    localparam int CW = $clog2(ILE_MAC_STEPS);

    logic [ILE_DATA_W-1:0] r_acc;
    logic [ILE_DATA_W-1:0] r_a;
    logic [ILE_MULT_W-1:0] r_b;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic                  last;

    assign last = (r_cnt == CW'(ILE_MAC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.init;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_rsp.busy    = r_busy;
    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// ----- verif/tb_interface_length_estimator.sv -----
// Testbench for interface_length_estimator: streams signed grid samples, writes the
// grid size and spacing over APB between frames, and checks every frame result.
// Depends on ile_pkg and the interface_length_estimator RTL.
`timescale 1ns / 100ps

module tb_interface_length_estimator
    import ile_pkg::*;
();

    localparam int          GRID_CAP       = ILE_MAX_GRID_DEF;
    localparam logic [31:0] ROOT2_Q20      = 32'd1482910;
    localparam logic [31:0] PI_OVER_32_Q32 = 32'd421657428;
    localparam logic [23:0] SPACING_MAX    = 24'hFF_FFFF;
    localparam int          CYCLE_LIMIT    = 2_000_000;
    localparam int          RANDOM_ITEMS   = 520;
    localparam int          HOLDOFF_CYCLES = 3000;
    localparam int          STRIPE_GRID    = 16;

    typedef struct packed {
        logic [39:0] length_estimate;
        logic [15:0] horizontal;
        logic [15:0] vertical;
        logic [14:0] diagonal;
        logic [14:0] antidiagonal;
    } t_frame_totals;

    typedef struct packed {
        logic [8:0]       grid;
        logic [23:0]      spacing;
        logic [3:0][15:0] samples;
        logic             typed;
        t_frame_totals    totals;
    } t_directed_frame;

    typedef enum int {
        FILL_NOISE,
        FILL_PLANE,
        FILL_EXTREME
    } t_fill;

    localparam logic [15:0] EXTREMES [5] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};

    localparam t_directed_frame DIRECTED [5] = '{
        '{9'd0, 24'd0, {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF}, 1'b1,
          '{40'd0, 16'd2, 16'd2, 15'd0, 15'd0}},
        '{9'd1, 24'd65536, {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
          '{40'd0, 16'd0, 16'd0, 15'd0, 15'd0}},
        '{9'd2, 24'hFF_FFFF, {16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001}, 1'b0, '0},
        '{9'd2, 24'd1, {16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{9'd2, 24'd65536, {16'h0000, 16'h7FFF, 16'h8000, 16'h0000}, 1'b0, '0}
    };

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_sample    = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [39:0] o_length_estimate;
    logic [15:0] o_horizontal_crossings;
    logic [15:0] o_vertical_crossings;
    logic [14:0] o_diagonal_crossings;
    logic [14:0] o_antidiagonal_crossings;

    t_sign       sign_row [GRID_CAP];
    t_sign       left_class   = SIGN_ZERO;
    t_sign       upleft_class = SIGN_ZERO;
    int          pos_row      = 0;
    int          pos_col      = 0;
    int          cnt_h        = 0;
    int          cnt_v        = 0;
    int          cnt_d        = 0;
    int          cnt_a        = 0;
    logic [8:0]  cfg_grid     = ILE_GRID_RESET;
    logic [23:0] cfg_spacing  = ILE_SPACING_RESET;

    t_frame_totals pending_frames [$];
    t_frame_totals typed_totals;
    bit            typed_due      = 1'b0;
    int            fail_count     = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            holdoff_left   = 0;
    int            random_items   = 0;
    int            frames_sent    = 0;

    interface_length_estimator #(
        .MAX_GRID(GRID_CAP)
    ) dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_sample                (i_sample),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_length_estimate       (o_length_estimate),
        .o_horizontal_crossings  (o_horizontal_crossings),
        .o_vertical_crossings    (o_vertical_crossings),
        .o_diagonal_crossings    (o_diagonal_crossings),
        .o_antidiagonal_crossings(o_antidiagonal_crossings)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_interface_length_estimator: FAIL");
            $finish;
        end
    end

    function automatic t_sign classify(input logic [15:0] s);
        t_sign cls;
        if (s == 16'h0000) begin
            cls = SIGN_ZERO;
        end else if (s[15]) begin
            cls = SIGN_NEG;
        end else begin
            cls = SIGN_POS;
        end
        return cls;
    endfunction

    function automatic bit opposite(input t_sign x, input t_sign y);
        return x != SIGN_ZERO && y != SIGN_ZERO && x != y;
    endfunction

    function automatic int effective_grid();
        int n;
        n = int'(cfg_grid);
        if (n < 2) n = 2;
        if (n > GRID_CAP) n = GRID_CAP;
        return n;
    endfunction

    function automatic logic [39:0] crofton_length(input int h, input int v, input int d,
                                                   input int a, input logic [23:0] dx);
        logic [127:0] acc;
        acc = (128'(h + v) << 20) + 128'(ROOT2_Q20) * 128'(d + a);
        acc = acc * 128'(dx);
        acc = (acc * 128'(PI_OVER_32_Q32) + (128'd1 << 51)) >> 52;
        return acc[39:0];
    endfunction

    function automatic logic [15:0] sample_of_class(input t_sign cls);
        logic [15:0] s;
        case (cls)
            SIGN_POS: s = 16'($urandom_range(32767, 1));
            SIGN_NEG: s = 16'(32'd0 - $urandom_range(32768, 1));
            default:  s = 16'h0000;
        endcase
        return s;
    endfunction

    // Advance the grid walk by one sample; returns the totals when the frame closes.
    task automatic crofton_step(input logic [15:0] s, output bit done, output t_frame_totals tot);
        int    n;
        int    r;
        int    c;
        t_sign cur;
        t_sign above;
        n     = effective_grid();
        r     = pos_row;
        c     = pos_col;
        cur   = classify(s);
        above = sign_row[c];
        done  = 1'b0;
        tot   = '0;
        if (c >= 1 && opposite(cur, left_class)) cnt_h++;
        if (r >= 1) begin
            if (opposite(cur, above)) cnt_v++;
            if (r + c <= n - 1 && c + 1 < GRID_CAP && opposite(cur, sign_row[c + 1])) cnt_d++;
            if (c >= 1 && c <= r && opposite(cur, upleft_class)) cnt_a++;
        end
        sign_row[c]  = cur;
        upleft_class = above;
        left_class   = cur;
        if (c + 1 >= n) begin
            pos_col = 0;
            if (r + 1 >= n) begin
                done = 1'b1;
                tot.length_estimate = crofton_length(cnt_h, cnt_v, cnt_d, cnt_a, cfg_spacing);
                tot.horizontal      = 16'(cnt_h);
                tot.vertical        = 16'(cnt_v);
                tot.diagonal        = 15'(cnt_d);
                tot.antidiagonal    = 15'(cnt_a);
                pos_row      = 0;
                cnt_h        = 0;
                cnt_v        = 0;
                cnt_d        = 0;
                cnt_a        = 0;
                left_class   = SIGN_ZERO;
                upleft_class = SIGN_ZERO;
            end else begin
                pos_row = r + 1;
            end
        end else begin
            pos_col = c + 1;
        end
    endtask

    task automatic send_sample(input logic [15:0] s);
        bit            done;
        t_frame_totals tot;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        crofton_step(s, done, tot);
        if (done) begin
            if (typed_due) begin
                pending_frames.push_back(typed_totals);
                typed_due = 1'b0;
            end else begin
                pending_frames.push_back(tot);
            end
        end
    endtask

    task automatic write_reg(input logic reg_code, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_code, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_code == ILE_REG_GRID_SIZE) begin
            cfg_grid = value[8:0];
        end else begin
            cfg_spacing = value[23:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_reg(input logic reg_code, output logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_code, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic await_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random_frame();
        int          n;
        int          r;
        int          c;
        int          ar;
        int          ac;
        int          k;
        int          level;
        t_fill       fill;
        t_sign       cls;
        logic [15:0] s;
        n    = effective_grid();
        fill = t_fill'($urandom_range(FILL_EXTREME, FILL_NOISE));
        ar   = int'($urandom_range(6)) - 3;
        ac   = int'($urandom_range(6)) - 3;
        k    = int'($urandom_range(2 * n)) - n;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                case (fill)
                    FILL_NOISE: begin
                        s = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
                    end
                    FILL_PLANE: begin
                        level = ar * r + ac * c + k;
                        cls   = (level > 0) ? SIGN_POS : (level < 0) ? SIGN_NEG : SIGN_ZERO;
                        if ($urandom_range(15) == 0) cls = t_sign'($urandom_range(2));
                        s = sample_of_class(cls);
                    end
                    default: begin
                        s = EXTREMES[$urandom_range(4)];
                    end
                endcase
                send_sample(s);
                random_items++;
            end
        end
        frames_sent++;
    endtask

    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            i_out_ready  <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_frame_totals want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_frames.size() == 0) begin
                $error("result with no frame outstanding");
                fail_count++;
            end else begin
                want = pending_frames.pop_front();
                check_field("length_estimate", want.length_estimate, o_length_estimate);
                check_field("horizontal_crossings", want.horizontal, o_horizontal_crossings);
                check_field("vertical_crossings", want.vertical, o_vertical_crossings);
                check_field("diagonal_crossings", want.diagonal, o_diagonal_crossings);
                check_field("antidiagonal_crossings", want.antidiagonal,
                            o_antidiagonal_crossings);
            end
        end
    end

    initial begin
        logic [31:0] readback;
        int          phase;
        int          frames;
        int          r;
        int          c;
        int          pick;
        int          target_items;
        int          target_frames;
        bit          first;

        foreach (sign_row[i]) sign_row[i] = SIGN_ZERO;
        send_idle_pct  = 7;
        recv_stall_pct = 54;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        read_reg(ILE_REG_GRID_SIZE, readback);
        check_field("grid_size", 32'(ILE_GRID_RESET), readback);
        read_reg(ILE_REG_CELL_SPACING, readback);
        check_field("cell_spacing", 32'(ILE_SPACING_RESET), readback);

        foreach (DIRECTED[i]) begin
            await_idle();
            write_reg(ILE_REG_GRID_SIZE, 32'(DIRECTED[i].grid));
            write_reg(ILE_REG_CELL_SPACING, 32'(DIRECTED[i].spacing));
            typed_due    = DIRECTED[i].typed;
            typed_totals = DIRECTED[i].totals;
            for (int k = 0; k < 4; k++) send_sample(DIRECTED[i].samples[k]);
        end

        // 16 by 16 frame of row stripes: every vertical, diagonal and anti-diagonal pair flips
        await_idle();
        write_reg(ILE_REG_GRID_SIZE, 32'(STRIPE_GRID));
        write_reg(ILE_REG_CELL_SPACING, 32'(SPACING_MAX));
        typed_due    = 1'b1;
        typed_totals = '{crofton_length(0, 240, 120, 120, SPACING_MAX),
                         16'd0, 16'd240, 15'd120, 15'd120};
        for (r = 0; r < STRIPE_GRID; r++) begin
            for (c = 0; c < STRIPE_GRID; c++) begin
                send_sample(sample_of_class(r[0] ? SIGN_NEG : SIGN_POS));
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 54;
                end
                1: begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 7;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            target_items  = RANDOM_ITEMS * (phase + 1) / 3;
            target_frames = 3 * (phase + 1);
            first         = 1'b1;
            while (random_items < target_items || frames_sent < target_frames) begin
                await_idle();
                if (first && phase == 2) begin
                    // hold the output side while small frames keep coming
                    write_reg(ILE_REG_GRID_SIZE, 32'd2);
                    frames = 6;
                    @(posedge i_clk);
                    holdoff_left = HOLDOFF_CYCLES;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 10) begin
                        write_reg(ILE_REG_GRID_SIZE, $urandom_range(1, 0));
                    end else if (pick < 80) begin
                        write_reg(ILE_REG_GRID_SIZE, $urandom_range(8, 2));
                    end else begin
                        write_reg(ILE_REG_GRID_SIZE, $urandom_range(16, 9));
                    end
                    if ($urandom_range(4) != 0) begin
                        pick = $urandom_range(99);
                        if (pick < 10) begin
                            write_reg(ILE_REG_CELL_SPACING, 32'd0);
                        end else if (pick < 20) begin
                            write_reg(ILE_REG_CELL_SPACING, 32'd1);
                        end else if (pick < 30) begin
                            write_reg(ILE_REG_CELL_SPACING, 32'(SPACING_MAX));
                        end else begin
                            write_reg(ILE_REG_CELL_SPACING, $urandom_range(SPACING_MAX, 1));
                        end
                    end
                    frames = $urandom_range(3, 1);
                end
                first = 1'b0;
                repeat (frames) send_random_frame();
            end
        end

        await_idle();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_interface_length_estimator: PASS");
        end else begin
            $display("tb_interface_length_estimator: FAIL");
        end
        $finish;
    end

endmodule

// ----- interface_length_estimator.f -----
hdl/ile_pkg.sv
hdl/ile_mac.sv
hdl/interface_length_estimator.sv
verif/tb_interface_length_estimator.sv
